// ===== design/bfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// bfcb_pkg - shared definitions for the clipped-border box filter
// Defaults, register indexes, the sequencer states and the lane controls.
// ----------------------------------------------------------------------------
package bfcb_pkg;

    localparam int RADIUS_DEF   = 1;
    localparam int MAX_COLS_DEF = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_END   = 3'd4;

    localparam logic [15:0] RST_IMAGE_ROWS = 16'd480;
    localparam logic [11:0] RST_IMAGE_COLS = 12'd640;
    localparam logic [1:0]  RST_CHANNELS   = 2'd3;
    localparam logic [15:0] RST_BAND_START = 16'd0;
    localparam logic [15:0] RST_BAND_END   = 16'd480;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_FLUSH,
        S_DIV,
        S_OUT,
        S_ADV
    } t_state;

    typedef struct packed {
        logic clr;
        logic acc_en;
        logic div_step;
    } t_lane_ctrl;

endpackage

// ===== design/bfcb_linebuf.sv =====
// ----------------------------------------------------------------------------
// bfcb_linebuf - line store ring
// One write port and one registered read port over the ring of image rows.
// ----------------------------------------------------------------------------
module bfcb_linebuf #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [23:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [23:0]       o_rdata
);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bfcb_lane.sv =====
// ----------------------------------------------------------------------------
// bfcb_lane - one channel lane
// Accumulates the window sum, then divides it by the window count one
// quotient bit per cycle in place.
// ----------------------------------------------------------------------------
module bfcb_lane #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 8
) (
    input  logic                 i_clk,
    input  bfcb_pkg::t_lane_ctrl i_ctrl,
    input  logic [7:0]           i_pix,
    input  logic [CNT_W-1:0]     i_cnt,
    output logic [7:0]           o_avg
);

    logic [SUM_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W:0]   trial;

    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        trial = {r_rem, r_acc[SUM_W-1]};
        if (i_ctrl.clr) begin
            n_acc = '0;
            n_rem = '0;
        end else if (i_ctrl.acc_en) begin
            n_acc = r_acc + SUM_W'(i_pix);
        end else if (i_ctrl.div_step) begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, i_cnt}) begin
                n_rem = CNT_W'(trial - {1'b0, i_cnt});
                n_acc = {r_acc[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = CNT_W'(trial);
                n_acc = {r_acc[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_avg = r_acc[7:0];

endmodule

// ===== design/box_filter_clipped_border_unit.sv =====
// ----------------------------------------------------------------------------
// box_filter_clipped_border_unit - streaming 2-D mean filter, clipped border
// Line store ring, window sequencer, three channel lanes and an output stage.
// ----------------------------------------------------------------------------
// Latency/throughput: input is taken only in the idle state, so a new item
// waits until the last is through. An item inside the band reads its clipped
// window (up to (2*RADIUS+1)^2 pixels) through the single read port of the line
// store, then divides the sum bit-serially in each lane and waits while the
// output stalls. Positions outside the band are stepped over without a result.
// Reset: synchronous, active low; configuration, positions, the sequencer and the
// valid flags clear at once; the line store and the datapath registers do not.
module box_filter_clipped_border_unit #(
    parameter int RADIUS   = bfcb_pkg::RADIUS_DEF,
    parameter int MAX_COLS = bfcb_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chan0, chan1, chan2
    input  logic        s_axis_tuser,   // drain
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // avg0, avg1, avg2, out_row, out_col, zero pad
    output logic        m_axis_tlast,   // last
    input  logic                            i_cfg_we,
    input  logic [bfcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfcb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RING   = 2 * RADIUS + 2;
    localparam int RING_W = $clog2(RING);
    localparam int DEPTH  = RING * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int WIN    = (2 * RADIUS + 1) * (2 * RADIUS + 1);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int SUM_W  = $clog2(255 * WIN + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int DIFF_W = $clog2(RADIUS * MAX_COLS + RADIUS + 2) + 1;

    // configuration
    logic [15:0] r_rows, r_bstart, r_bend;
    logic [11:0] r_cols;
    logic [1:0]  r_chans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= bfcb_pkg::RST_IMAGE_ROWS;
            r_cols   <= bfcb_pkg::RST_IMAGE_COLS;
            r_chans  <= bfcb_pkg::RST_CHANNELS;
            r_bstart <= bfcb_pkg::RST_BAND_START;
            r_bend   <= bfcb_pkg::RST_BAND_END;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfcb_pkg::REG_IMAGE_ROWS: r_rows   <= i_cfg_data;
                bfcb_pkg::REG_IMAGE_COLS: r_cols   <= i_cfg_data[11:0];
                bfcb_pkg::REG_CHANNELS:   r_chans  <= i_cfg_data[1:0];
                bfcb_pkg::REG_BAND_START: r_bstart <= i_cfg_data;
                bfcb_pkg::REG_BAND_END:   r_bend   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0]       rows_e, band_hi;
    logic [COL_W-1:0]  cols_e;
    logic [1:0]        chans_e;
    logic [DIFF_W-1:0] lag;

    always_comb begin
        rows_e  = (r_rows == 16'd0) ? 16'd1 : r_rows;
        if (r_cols == 12'd0) begin
            cols_e = COL_W'(1);
        end else if ({4'd0, r_cols} > 16'(MAX_COLS)) begin
            cols_e = COL_W'(MAX_COLS);
        end else begin
            cols_e = COL_W'(r_cols);
        end
        chans_e = (r_chans == 2'd0) ? 2'd1 : r_chans;
        band_hi = (r_bend < rows_e) ? r_bend : rows_e;
        lag = DIFF_W'(RADIUS * cols_e)
            + ((COL_W'(RADIUS) < cols_e - COL_W'(1)) ? DIFF_W'(RADIUS)
                                                     : DIFF_W'(cols_e - COL_W'(1)));
    end

    // sequencer and position state
    bfcb_pkg::t_state r_state, n_state;

    logic [15:0]       r_in_row, n_in_row, r_out_row, n_out_row;
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RING_W-1:0] r_in_ring, n_in_ring, r_out_ring, n_out_ring;
    logic [DIFF_W-1:0] r_diff, n_diff;

    logic [15:0]       r_rd_row, n_rd_row, r_rhi, n_rhi;
    logic [COL_W-1:0]  r_rd_col, n_rd_col, r_clo, n_clo, r_chi, n_chi;
    logic [RING_W-1:0] r_rd_ring, n_rd_ring;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_rd_vld, n_rd_vld;

    logic [55:0] r_tdata, n_tdata;
    logic        r_tlast, n_tlast, r_tvalid, n_tvalid;

    logic              in_xfer, pix_we, mem_re, ready, emit, out_free;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [16:0]       r_ext, c_ext;
    logic [15:0]       r_lo, r_hi;
    logic [COL_W-1:0]  c_lo, c_hi, adv_col;
    logic [RING_W-1:0] ring_back;
    logic [23:0]       rdata;
    logic [7:0]        avg [3];
    bfcb_pkg::t_lane_ctrl lane_ctrl;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_tvalid || m_axis_tready;
    assign ready    = (r_in_row >= rows_e) || (r_diff > lag);
    assign emit     = (r_out_row >= r_bstart) && (r_out_row < band_hi);

    // clipped window bounds of the current output position
    always_comb begin
        r_ext = {1'b0, r_out_row} + 17'(RADIUS);
        c_ext = 17'(r_out_col) + 17'(RADIUS);
        r_lo  = (r_out_row >= 16'(RADIUS)) ? r_out_row - 16'(RADIUS) : 16'd0;
        r_hi  = (r_ext >= {1'b0, rows_e}) ? rows_e - 16'd1 : r_ext[15:0];
        c_lo  = (r_out_col >= COL_W'(RADIUS)) ? r_out_col - COL_W'(RADIUS) : '0;
        c_hi  = (c_ext >= 17'(cols_e)) ? cols_e - COL_W'(1) : COL_W'(c_ext);
        ring_back = RING_W'(r_out_row - r_lo);
        adv_col = r_out_col + COL_W'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfcb_pkg::S_IDLE:  if (s_axis_tvalid) n_state = bfcb_pkg::S_CHECK;
            bfcb_pkg::S_CHECK: begin
                if (!ready) begin
                    n_state = bfcb_pkg::S_IDLE;
                end else if (emit) begin
                    n_state = bfcb_pkg::S_SUM;
                end else begin
                    n_state = bfcb_pkg::S_ADV;
                end
            end
            bfcb_pkg::S_SUM: begin
                if (r_rd_row == r_rhi && r_rd_col == r_chi) n_state = bfcb_pkg::S_FLUSH;
            end
            bfcb_pkg::S_FLUSH: n_state = bfcb_pkg::S_DIV;
            bfcb_pkg::S_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) n_state = bfcb_pkg::S_OUT;
            end
            bfcb_pkg::S_OUT:   if (out_free) n_state = bfcb_pkg::S_ADV;
            bfcb_pkg::S_ADV:   n_state = bfcb_pkg::S_IDLE;
            default:           n_state = bfcb_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_in_ring  = r_in_ring;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_ring = r_out_ring;
        n_diff     = r_diff;
        n_rd_row   = r_rd_row;
        n_rd_col   = r_rd_col;
        n_rd_ring  = r_rd_ring;
        n_rhi      = r_rhi;
        n_clo      = r_clo;
        n_chi      = r_chi;
        n_cnt      = r_cnt;
        n_step     = r_step;
        n_rd_vld   = 1'b0;
        n_tdata    = r_tdata;
        n_tlast    = r_tlast;
        n_tvalid   = (r_tvalid && m_axis_tready) ? 1'b0 : r_tvalid;
        pix_we     = 1'b0;
        mem_re     = 1'b0;
        lane_ctrl  = '0;
        lane_ctrl.acc_en = r_rd_vld;
        s_axis_tready = (r_state == bfcb_pkg::S_IDLE);

        if (r_rd_vld) n_cnt = r_cnt + CNT_W'(1);

        case (r_state)
            bfcb_pkg::S_IDLE: begin
                if (in_xfer && !s_axis_tuser && r_in_row < rows_e) begin
                    pix_we = 1'b1;
                    n_diff = r_diff + DIFF_W'(1);
                    if (r_in_col + COL_W'(1) >= cols_e) begin
                        n_in_col  = '0;
                        n_in_row  = r_in_row + 16'd1;
                        n_in_ring = (r_in_ring == RING_W'(RING - 1)) ? '0
                                                                    : r_in_ring + RING_W'(1);
                    end else begin
                        n_in_col = r_in_col + COL_W'(1);
                    end
                end
            end
            bfcb_pkg::S_CHECK: begin
                if (ready && emit) begin
                    lane_ctrl.clr = 1'b1;
                    n_cnt    = '0;
                    n_rd_row = r_lo;
                    n_rhi    = r_hi;
                    n_rd_col = c_lo;
                    n_clo    = c_lo;
                    n_chi    = c_hi;
                    n_rd_ring = (r_out_ring >= ring_back)
                              ? r_out_ring - ring_back
                              : RING_W'(r_out_ring + RING_W'(RING) - ring_back);
                end
            end
            bfcb_pkg::S_SUM: begin
                mem_re   = 1'b1;
                n_rd_vld = 1'b1;
                if (r_rd_col == r_chi) begin
                    n_rd_col  = r_clo;
                    n_rd_row  = r_rd_row + 16'd1;
                    n_rd_ring = (r_rd_ring == RING_W'(RING - 1)) ? '0
                                                                : r_rd_ring + RING_W'(1);
                end else begin
                    n_rd_col = r_rd_col + COL_W'(1);
                end
                n_step = '0;
            end
            bfcb_pkg::S_FLUSH: n_step = '0;
            bfcb_pkg::S_DIV: begin
                lane_ctrl.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
            end
            bfcb_pkg::S_OUT: begin
                if (out_free) begin
                    n_tvalid = 1'b1;
                    n_tdata  = {5'd0,
                                11'(r_out_col),
                                r_out_row - r_bstart,
                                (chans_e > 2'd2) ? avg[2] : 8'd0,
                                (chans_e > 2'd1) ? avg[1] : 8'd0,
                                avg[0]};
                    n_tlast  = (r_out_row == band_hi - 16'd1)
                            && (r_out_col == cols_e - COL_W'(1));
                end
            end
            bfcb_pkg::S_ADV: begin
                n_diff = r_diff - DIFF_W'(1);
                if (adv_col >= cols_e) begin
                    n_out_col  = '0;
                    n_out_row  = r_out_row + 16'd1;
                    n_out_ring = (r_out_ring == RING_W'(RING - 1)) ? '0
                                                                  : r_out_ring + RING_W'(1);
                    // frame end: both positions return to the origin
                    if (r_out_row + 16'd1 >= rows_e) begin
                        n_out_row  = '0;
                        n_out_ring = '0;
                        n_in_row   = '0;
                        n_in_col   = '0;
                        n_in_ring  = '0;
                        n_diff     = '0;
                    end
                end else begin
                    n_out_col = adv_col;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bfcb_pkg::S_IDLE;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_diff     <= '0;
            r_rd_vld   <= 1'b0;
            r_tvalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_ring  <= n_in_ring;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_ring <= n_out_ring;
            r_diff     <= n_diff;
            r_rd_vld   <= n_rd_vld;
            r_tvalid   <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row  <= n_rd_row;
        r_rd_col  <= n_rd_col;
        r_rd_ring <= n_rd_ring;
        r_rhi     <= n_rhi;
        r_clo     <= n_clo;
        r_chi     <= n_chi;
        r_cnt     <= n_cnt;
        r_step    <= n_step;
        r_tdata   <= n_tdata;
        r_tlast   <= n_tlast;
    end

    assign waddr = ADDR_W'(r_in_ring * MAX_COLS) + ADDR_W'(r_in_col);
    assign raddr = ADDR_W'(r_rd_ring * MAX_COLS) + ADDR_W'(r_rd_col);

    bfcb_linebuf #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (mem_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        bfcb_lane #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (lane_ctrl),
            .i_pix  (rdata[8*g +: 8]),
            .i_cnt  (r_cnt),
            .o_avg  (avg[g])
        );
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for box_filter_clipped_border_unit
// Streams whole frames of random, checkerboard or flat pixels through the
// filter. Each frame uses its own geometry, channel count and band. A built-in
// mean-filter predictor works out every expected output pixel. Random input gaps
// and output stalls; the configuration is rewritten only between frames.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAD     = bfcb_pkg::RADIUS_DEF;
    localparam int MCOLS   = bfcb_pkg::MAX_COLS_DEF;
    localparam int RING    = 2 * RAD + 2;
    localparam int N_ITEMS = 1950;

    localparam int MODE_RANDOM  = 0;
    localparam int MODE_CHECKER = 1;
    localparam int MODE_FLAT    = 2;

    typedef struct packed {
        logic       drain;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } t_pixel;

    typedef struct packed {
        logic        last;
        logic [10:0] col;
        logic [15:0] row;
        logic [7:0]  a2;
        logic [7:0]  a1;
        logic [7:0]  a0;
    } t_mean;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // chan0, chan1, chan2
    logic        s_axis_tuser = 1'b0; // drain
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // avg0, avg1, avg2, out_row, out_col, zero pad
    logic        m_axis_tlast;        // last
    logic                            i_cfg_we = 1'b0;
    logic [bfcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [bfcb_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    box_filter_clipped_border_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- predictor state ----
    logic [23:0] pix_store [0:RING*MCOLS-1];
    int unsigned in_r, in_c, out_r, out_c;
    int unsigned cfg_rows, cfg_cols, cfg_chans, cfg_bstart, cfg_bend;

    t_pixel pending_pixels[$];
    t_mean  expected_means[$];
    int     fail_count = 0;
    int     items_made = 0;
    bit     calm_in = 1'b0;
    bit     calm_out = 1'b0;

    function automatic void filter_step(input t_pixel p);
        int unsigned rows, cols, nch, r, c, rr, cc, r_lo, r_hi, c_lo, c_hi;
        int unsigned cnt, band_hi, s;
        int unsigned sums [3];
        longint unsigned total, lag, have, need, k;
        t_mean m;
        rows  = (cfg_rows == 0) ? 1 : cfg_rows;
        cols  = (cfg_cols == 0) ? 1 : cfg_cols;
        cols  = (cols > MCOLS) ? MCOLS : cols;
        nch   = (cfg_chans == 0) ? 1 : cfg_chans;
        total = longint'(rows) * cols;
        lag   = longint'(RAD) * cols + ((RAD < cols - 1) ? RAD : cols - 1);

        if (in_c >= cols) begin
            in_c = 0;
            in_r++;
        end
        if (in_r > rows) in_r = rows;
        if (!p.drain && in_r < rows) begin
            pix_store[(in_r % RING) * MCOLS + (in_c % MCOLS)] = {p.c2, p.c1, p.c0};
            if (++in_c >= cols) begin
                in_c = 0;
                in_r++;
            end
        end
        if (out_c >= cols) begin
            out_c = 0;
            out_r++;
        end
        if (out_r >= rows) begin
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            return;
        end
        have = longint'(in_r) * cols + in_c;
        k    = longint'(out_r) * cols + out_c;
        need = k + lag + 1;
        if (need > total) need = total;
        if (have < need) return;

        r = out_r;
        c = out_c;
        r_lo = (r >= RAD) ? r - RAD : 0;
        r_hi = (r + RAD >= rows) ? rows - 1 : r + RAD;
        c_lo = (c >= RAD) ? c - RAD : 0;
        c_hi = (c + RAD >= cols) ? cols - 1 : c + RAD;
        cnt = 0;
        sums = '{0, 0, 0};
        for (rr = r_lo; rr <= r_hi; rr++)
            for (cc = c_lo; cc <= c_hi; cc++) begin
                s = (rr % RING) * MCOLS + (cc % MCOLS);
                cnt++;
                sums[0] += pix_store[s][7:0];
                sums[1] += pix_store[s][15:8];
                sums[2] += pix_store[s][23:16];
            end
        band_hi = (cfg_bend < rows) ? cfg_bend : rows;
        if (r >= cfg_bstart && r < band_hi) begin
            m.a0   = 8'(sums[0] / cnt);
            m.a1   = (nch > 1) ? 8'(sums[1] / cnt) : 8'd0;
            m.a2   = (nch > 2) ? 8'(sums[2] / cnt) : 8'd0;
            m.row  = 16'(r - cfg_bstart);
            m.col  = 11'(c);
            m.last = (r == band_hi - 1 && c == cols - 1);
            expected_means.push_back(m);
        end
        if (++out_c >= cols) begin
            out_c = 0;
            out_r++;
        end
        if (out_r >= rows) begin
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        end
    endfunction

    function automatic void queue_pixel(input t_pixel p);
        pending_pixels.push_back(p);
        filter_step(p);
        items_made++;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p = t_pixel'({1'b0, 24'($urandom)});
        return p;
    endfunction

    function automatic bit frame_open();
        return !(in_r == 0 && in_c == 0 && out_r == 0 && out_c == 0);
    endfunction

    // One frame: every pixel, sparse drains mixed in, then mostly drains until it closes.
    // Pixels sent past the image end are dropped by the block.
    function automatic void queue_frame(input int mode);
        int unsigned rows, cols, n;
        t_pixel p;
        rows = (cfg_rows == 0) ? 1 : cfg_rows;
        cols = (cfg_cols == 0) ? 1 : cfg_cols;
        cols = (cols > MCOLS) ? MCOLS : cols;
        for (n = 0; n < rows * cols; n++) begin
            if ($urandom_range(0, 19) == 0) queue_pixel(t_pixel'({1'b1, 24'($urandom)}));
            case (mode)
                MODE_CHECKER: p = t_pixel'({1'b0, (n % 2) ? 24'hFFFFFF : 24'h000000});
                MODE_FLAT:    p = t_pixel'({1'b0, 24'hFFFFFF});
                default:      p = rand_pixel();
            endcase
            queue_pixel(p);
        end
        while (frame_open()) begin
            p = ($urandom_range(0, 9) == 0) ? rand_pixel() : t_pixel'({1'b1, 24'($urandom)});
            queue_pixel(p);
        end
    endfunction

    task automatic write_reg(input logic [bfcb_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 16'(val);
        case (idx)
            bfcb_pkg::REG_IMAGE_ROWS: cfg_rows   = val & 16'hFFFF;
            bfcb_pkg::REG_IMAGE_COLS: cfg_cols   = val & 12'hFFF;
            bfcb_pkg::REG_CHANNELS:   cfg_chans  = val & 2'h3;
            bfcb_pkg::REG_BAND_START: cfg_bstart = val & 16'hFFFF;
            bfcb_pkg::REG_BAND_END:   cfg_bend   = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned rows, cols, chans, bstart, bend);
        write_reg(bfcb_pkg::REG_IMAGE_ROWS, rows);
        write_reg(bfcb_pkg::REG_IMAGE_COLS, cols);
        write_reg(bfcb_pkg::REG_CHANNELS, chans);
        write_reg(bfcb_pkg::REG_BAND_START, bstart);
        write_reg(bfcb_pkg::REG_BAND_END, bend);
    endtask

    // Hold until every transfer went through and every mean came back.
    task automatic settle();
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_means.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic run_frame(input int unsigned rows, cols, chans, bstart, bend,
                             input int mode);
        set_frame(rows, cols, chans, bstart, bend);
        queue_frame(mode);
        settle();
    endtask

    // ---- input driver ----
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if ($urandom_range(0, 299) == 0) calm_in = ~calm_in;
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                t_pixel p;
                p = pending_pixels.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {p.c2, p.c1, p.c0};
                s_axis_tuser  <= p.drain;
                if (!calm_in)
                    in_gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---- output monitor ----
    int out_stall = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_mean want;
                t_mean got;
                got = t_mean'({m_axis_tlast, m_axis_tdata[50:0]});
                if (expected_means.size() == 0) begin
                    $error("unexpected output transfer row=%0d col=%0d", got.row, got.col);
                    fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (got.a0 !== want.a0) begin
                        $error("avg0: expected %0d, got %0d", want.a0, got.a0);
                        fail_count++;
                    end
                    if (got.a1 !== want.a1) begin
                        $error("avg1: expected %0d, got %0d", want.a1, got.a1);
                        fail_count++;
                    end
                    if (got.a2 !== want.a2) begin
                        $error("avg2: expected %0d, got %0d", want.a2, got.a2);
                        fail_count++;
                    end
                    if (got.row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, got.row);
                        fail_count++;
                    end
                    if (got.col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, got.col);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 299) == 0) calm_out = ~calm_out;
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm_out && $urandom_range(0, 3) == 0)
                    out_stall = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                                             : $urandom_range(1, 2);
            end
        end
    end

    initial begin
        int unsigned rows, cols, bs, be;
        for (int i = 0; i < RING * MCOLS; i++) pix_store[i] = '0;
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        cfg_rows = bfcb_pkg::RST_IMAGE_ROWS;
        cfg_cols = bfcb_pkg::RST_IMAGE_COLS;
        cfg_chans = bfcb_pkg::RST_CHANNELS;
        cfg_bstart = bfcb_pkg::RST_BAND_START;
        cfg_bend = bfcb_pkg::RST_BAND_END;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale checkerboard, degenerate geometry, empty bands
        run_frame(3, 4, 3, 0, 3, MODE_CHECKER);
        run_frame(0, 0, 0, 0, 16'hFFFF, MODE_FLAT);
        run_frame(2, 3, 2, 16'hFFFF, 0, MODE_RANDOM);
        run_frame(2, 2, 1, 1, 1, MODE_RANDOM);
        run_frame(1, 5, 3, 0, 16'hFFFF, MODE_FLAT);

        while (items_made < N_ITEMS) begin
            rows = $urandom_range(1, 7);
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
            bs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16'hFFFF)
                                             : $urandom_range(0, rows - 1);
            be = ($urandom_range(0, 4) == 0) ? 16'hFFFF : $urandom_range(bs, rows + 1);
            run_frame(rows, cols, $urandom_range(0, 3), bs, be, MODE_RANDOM);
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== box_filter_clipped_border_unit.f =====
design/bfcb_pkg.sv
design/bfcb_linebuf.sv
design/bfcb_lane.sv
design/box_filter_clipped_border_unit.sv
tb/tb.sv
